>>> design/adc_pkg.sv
// ----------------------------------------------------------------------------
// adc_pkg
// Shared types, constants and helpers for the distortion chain.
// ----------------------------------------------------------------------------
package adc_pkg;

  // sample and state formats
  localparam int SAMPLE_W = 24;
  localparam int STATE_W  = 32;
  localparam int FRAC     = SAMPLE_W - 1;
  localparam int WIDE_W   = 44;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;

  localparam longint ONE_Q    = 64'sd1 <<< FRAC;
  localparam longint NEG_CLIP = (ONE_Q * 7 + 5) / 10;
  localparam longint DRV_LIM  = 4 * ONE_Q;
  localparam longint STATE_HI = (64'sd1 <<< (STATE_W - 1)) - 1;

  // knobs, unsigned Q1.16
  localparam int KNOB_W = 17;
  typedef logic [KNOB_W-1:0] knob_t;
  localparam knob_t KNOB_ONE = 17'h10000;
  localparam int    DC_R     = 65208;

  // configuration port
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN     = 3'd0,
    REG_TONE     = 3'd1,
    REG_PRESENCE = 3'd2,
    REG_LEVEL    = 3'd3,
    REG_LPA      = 3'd4,
    REG_HPA      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    knob_t gain;
    knob_t tone;
    knob_t presence;
    knob_t level;
    knob_t lpa;
    knob_t hpa;
  } knobs_t;

  // digit-serial multiplier geometry
  localparam int MUL_AW  = 32;
  localparam int MUL_KW  = 24;
  localparam int DIGIT_W = 4;
  localparam int NDIG    = MUL_KW / DIGIT_W;
  localparam int PROD_W  = MUL_AW + MUL_KW;
  localparam int RES_W   = PROD_W - 16 + 1;
  localparam int CNT_W   = $clog2(NDIG);

  typedef logic signed [RES_W-1:0] mul_res_t;

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic [MUL_KW-1:0]        k;
  } mul_req_t;

  typedef struct packed {
    logic     done;
    mul_res_t r;
  } mul_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DC,
    ST_DRV,
    ST_LP1,
    ST_LP2,
    ST_T1,
    ST_T2,
    ST_HP,
    ST_PR,
    ST_LV
  } seq_state_t;

  function automatic wide_t clamp_w(wide_t v, wide_t lo, wide_t hi);
    wide_t res;
    res = v;
    if (v < lo) res = lo;
    if (v > hi) res = hi;
    return res;
  endfunction

  function automatic state_t sat_state(wide_t v);
    wide_t c;
    c = clamp_w(v, -wide_t'(STATE_HI) - wide_t'(1), wide_t'(STATE_HI));
    return c[STATE_W-1:0];
  endfunction

endpackage

>>> design/adc_cfg.sv
// ----------------------------------------------------------------------------
// adc_cfg
// Knob register file; values above one read back as one.
// ----------------------------------------------------------------------------
module adc_cfg
  import adc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KNOB_W-1:0]    cfg_data,
  output knobs_t               knobs
);

  knob_t gain, tone, presence, level, lpa, hpa;

  assign cfg_ready = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= 17'd32768;
      tone     <= 17'd32768;
      presence <= 17'd19661;
      level    <= 17'd39322;
      lpa      <= 17'd12290;
      hpa      <= 17'd54924;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN:     gain     <= cfg_data;
        REG_TONE:     tone     <= cfg_data;
        REG_PRESENCE: presence <= cfg_data;
        REG_LEVEL:    level    <= cfg_data;
        REG_LPA:      lpa      <= cfg_data;
        REG_HPA:      hpa      <= cfg_data;
        default: ;
      endcase
    end
  end

  // limit to 1.0
  always_comb begin
    knobs.gain     = (gain     > KNOB_ONE) ? KNOB_ONE : gain;
    knobs.tone     = (tone     > KNOB_ONE) ? KNOB_ONE : tone;
    knobs.presence = (presence > KNOB_ONE) ? KNOB_ONE : presence;
    knobs.level    = (level    > KNOB_ONE) ? KNOB_ONE : level;
    knobs.lpa      = (lpa      > KNOB_ONE) ? KNOB_ONE : lpa;
    knobs.hpa      = (hpa      > KNOB_ONE) ? KNOB_ONE : hpa;
  end

endmodule

>>> design/adc_mul.sv
// ----------------------------------------------------------------------------
// adc_mul
// Digit-serial sign-magnitude multiplier by an unsigned Q.16 factor,
// four factor bits per cycle, rounded half away from zero.
// ----------------------------------------------------------------------------
module adc_mul
  import adc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(NDIG - 1);

  logic              busy;
  logic              rnd;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] p;
  logic [PROD_W-1:0] p_next;
  logic [MUL_AW-1:0] m;
  logic              neg;
  mul_res_t          r;
  logic [MUL_AW+DIGIT_W-1:0] part;
  logic [PROD_W-1:0] rounded;

  // control: load, NDIG digit steps, one rounding step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= rnd;
      rnd  <= busy && (cnt == LAST);
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST) busy <= 1'b0;
      end
    end
  end

  // one digit: upper half += m * digit, shift right by a digit
  always_comb begin
    part   = {{DIGIT_W{1'b0}}, p[PROD_W-1:MUL_KW]}
           + m * {{MUL_AW{1'b0}}, p[DIGIT_W-1:0]};
    p_next = {part, p[MUL_KW-1:DIGIT_W]};
    rounded = p + PROD_W'(32768);
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      p   <= {{MUL_AW{1'b0}}, req.k};
      m   <= req.a[MUL_AW-1] ? (~req.a + MUL_AW'(1)) : req.a;
      neg <= req.a[MUL_AW-1];
    end else if (busy) begin
      p <= p_next;
    end
    if (rnd) begin
      r <= neg ? -$signed({1'b0, rounded[PROD_W-1:16]})
               :  $signed({1'b0, rounded[PROD_W-1:16]});
    end
  end

  assign rsp.done = done;
  assign rsp.r    = r;

endmodule

>>> design/asymmetric_distortion_chain_unit.sv
// Sequence: nine multiplies per sample, each a start, six digit steps, rounding
//   and hand-off, from input transfer to output valid.
// Flow: a sample is taken only once the last is through the single shared
//   four-bit-digit serial multiplier; the level step waits on a pending output.
// Reset: synchronous, active high; knobs return to defaults and all filter
//   state clears to zero.
// ----------------------------------------------------------------------------
// asymmetric_distortion_chain_unit
// DC blocker, drive, asymmetric clip, tone low-pass, presence high-pass and
// level, sequenced over one shared digit-serial multiplier.
// ----------------------------------------------------------------------------
module asymmetric_distortion_chain_unit
  import adc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  sample_in,
  input  logic                 end_of_block,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  sample_out,
  output logic                 end_of_block_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KNOB_W-1:0]    cfg_data
);

  knobs_t     knobs;
  mul_req_t   req;
  mul_rsp_t   rsp;
  seq_state_t state, state_next;
  logic       issued;

  sample_t x;
  logic    eob;
  state_t  dc_prev_in, dc_prev_out, lp_mem, hp_prev_in, hp_prev_out;
  state_t  dc, clipped, hsum, present;
  mul_res_t t1;
  wide_t   toned;
  wide_t   rw;
  wide_t   v;

  adc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .knobs     (knobs)
  );

  adc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign in_ready = (state == ST_IDLE);
  assign rw       = wide_t'(rsp.r);

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.done)       issued <= 1'b0;
      else if (req.start) issued <= 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DC;
      ST_DC:   if (rsp.done) state_next = ST_DRV;
      ST_DRV:  if (rsp.done) state_next = ST_LP1;
      ST_LP1:  if (rsp.done) state_next = ST_LP2;
      ST_LP2:  if (rsp.done) state_next = ST_T1;
      ST_T1:   if (rsp.done) state_next = ST_T2;
      ST_T2:   if (rsp.done) state_next = ST_HP;
      ST_HP:   if (rsp.done) state_next = ST_PR;
      ST_PR:   if (rsp.done) state_next = ST_LV;
      ST_LV:   if (rsp.done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier operands
  always_comb begin
    req.start = 1'b0;
    req.a     = '0;
    req.k     = '0;
    unique case (state)
      ST_IDLE: ;
      ST_DC: begin
        req.a = dc_prev_out;
        req.k = MUL_KW'(DC_R);
      end
      ST_DRV: begin
        req.a = MUL_AW'(clamp_w(wide_t'(dc), -wide_t'(DRV_LIM), wide_t'(DRV_LIM)));
        req.k = MUL_KW'(KNOB_ONE) + MUL_KW'(knobs.gain) * MUL_KW'(99);
      end
      ST_LP1: begin
        req.a = clipped;
        req.k = MUL_KW'(knobs.lpa);
      end
      ST_LP2: begin
        req.a = lp_mem;
        req.k = MUL_KW'(KNOB_ONE - knobs.lpa);
      end
      ST_T1: begin
        req.a = clipped;
        req.k = MUL_KW'(knobs.tone);
      end
      ST_T2: begin
        req.a = lp_mem;
        req.k = MUL_KW'(KNOB_ONE - knobs.tone);
      end
      ST_HP: begin
        req.a = hsum;
        req.k = MUL_KW'(knobs.hpa);
      end
      ST_PR: begin
        req.a = hp_prev_out;
        req.k = MUL_KW'(knobs.presence);
      end
      ST_LV: begin
        req.a = present;
        req.k = MUL_KW'(knobs.level);
      end
      default: ;
    endcase
    if (state != ST_IDLE && !issued && (state != ST_LV || !out_valid))
      req.start = 1'b1;
  end

  // filter state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_prev_in  <= '0;
      dc_prev_out <= '0;
      lp_mem      <= '0;
      hp_prev_in  <= '0;
      hp_prev_out <= '0;
    end else if (rsp.done) begin
      case (state)
        ST_DC: begin
          dc_prev_in  <= STATE_W'(x);
          dc_prev_out <= sat_state(wide_t'(x) - wide_t'(dc_prev_in) + rw);
        end
        ST_LP2: lp_mem <= sat_state(wide_t'(t1) + rw);
        ST_T2:  hp_prev_in <= sat_state(wide_t'(t1) + rw);
        ST_HP:  hp_prev_out <= sat_state(rw);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x   <= sample_in;
      eob <= end_of_block;
    end
    if (rsp.done) begin
      case (state)
        ST_DC:  dc <= sat_state(wide_t'(x) - wide_t'(dc_prev_in) + rw);
        ST_DRV: clipped <= STATE_W'(clamp_w(rw, -wide_t'(NEG_CLIP), wide_t'(ONE_Q)));
        ST_LP1: t1 <= rsp.r;
        ST_T1:  t1 <= rsp.r;
        ST_T2: begin
          toned <= wide_t'(t1) + rw;
          hsum  <= sat_state(wide_t'(hp_prev_out) + wide_t'(t1) + rw
                             - wide_t'(hp_prev_in));
        end
        ST_PR:  present <= STATE_W'(clamp_w(toned + rw, -wide_t'(ONE_Q), wide_t'(ONE_Q)));
        default: ;
      endcase
    end
  end

  // output register
  assign v = clamp_w(rw, -wide_t'(ONE_Q), wide_t'(ONE_Q) - wide_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp.done && state == ST_LV) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done && state == ST_LV) begin
      sample_out       <= v[SAMPLE_W-1:0];
      end_of_block_out <= eob;
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Distortion chain testbench
// Drives audio samples and knob writes into the distortion chain. A scoreboard
// computes each expected output sample from its own fixed-point copy of the
// filter state and compares it with what the block returns.
// ----------------------------------------------------------------------------

// Expected-sample tracker: fixed-point model of the chain plus a FIFO
class distortion_scoreboard;
  localparam longint ONE   = 64'sd1 <<< 23;
  localparam longint S_HI  = (64'sd1 <<< 31) - 1;
  localparam longint S_LO  = -(64'sd1 <<< 31);
  localparam longint KONE  = 65536;

  longint knob_reg [6];
  longint dc_x, dc_y, lp_mem, hp_x, hp_y;
  logic [24:0] pending_q [$];
  int errors;
  int reported;

  function void clear_state();
    knob_reg[0] = 32768; knob_reg[1] = 32768; knob_reg[2] = 19661;
    knob_reg[3] = 39322; knob_reg[4] = 12290; knob_reg[5] = 54924;
    dc_x = 0; dc_y = 0; lp_mem = 0; hp_x = 0; hp_y = 0;
    errors = 0;
    reported = 0;
  endfunction

  function void write_knob(int idx, longint val);
    if (idx < 6) knob_reg[idx] = val & 64'h1FFFF;
  endfunction

  function longint knob_val(int idx);
    return (knob_reg[idx] > KONE) ? KONE : knob_reg[idx];
  endfunction

  // product with an unsigned Q8.16 factor, rounded half away from zero
  function longint scale_q16(longint a, longint k);
    longint m;
    longint r;
    m = (a < 0) ? -a : a;
    r = (m * k + 32768) >>> 16;
    return (a < 0) ? -r : r;
  endfunction

  function longint limit(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // note an offered input sample and queue its expected output
  function void note_input(logic [23:0] smp, logic eob);
    longint x, dc, drv, drv_gain, clipped, toned, hsum, hp, present, y;
    longint neg_clip;
    longint lpa, tone;
    x = longint'($signed(smp));
    lpa = knob_val(4);
    tone = knob_val(1);
    neg_clip = -((ONE * 7 + 5) / 10);
    dc = limit(x - dc_x + scale_q16(dc_y, 65208), S_LO, S_HI);
    dc_x = x;
    dc_y = dc;
    drv_gain = KONE + 99 * knob_val(0);
    drv = scale_q16(limit(dc, -4 * ONE, 4 * ONE), drv_gain);
    clipped = limit(drv, neg_clip, ONE);
    lp_mem = limit(scale_q16(clipped, lpa) + scale_q16(lp_mem, KONE - lpa), S_LO, S_HI);
    toned = scale_q16(clipped, tone) + scale_q16(lp_mem, KONE - tone);
    hsum = limit(hp_y + toned - hp_x, S_LO, S_HI);
    hp = limit(scale_q16(hsum, knob_val(5)), S_LO, S_HI);
    hp_x = limit(toned, S_LO, S_HI);
    hp_y = hp;
    present = limit(toned + scale_q16(hp, knob_val(2)), -ONE, ONE);
    y = limit(scale_q16(present, knob_val(3)), -ONE, ONE - 1);
    pending_q.push_back({eob, y[23:0]});
  endfunction

  // compare one output transfer with the oldest expectation
  function void check_output(logic [23:0] smp, logic eob);
    logic [24:0] exp_v;
    if (pending_q.size() == 0) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("unexpected output sample %0d eob %0b", $signed(smp), eob);
      end
      return;
    end
    exp_v = pending_q.pop_front();
    if (exp_v[23:0] !== smp || exp_v[24] !== eob) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("sample mismatch: expected %0d eob %0b, got %0d eob %0b",
                 $signed(exp_v[23:0]), exp_v[24], $signed(smp), eob);
      end
    end
  endfunction
endclass

module testbench;
  import adc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  sample_in = '0;
  logic                 end_of_block = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SAMPLE_W-1:0]  sample_out;
  logic                 end_of_block_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KNOB_W-1:0]    cfg_data = '0;

  distortion_scoreboard chain_sb;
  bit hold_off = 1'b0;

  asymmetric_distortion_chain_unit dut (.*);

  always #6 clk = ~clk;

  // overall time limit
  initial begin
    #(12 * 900000);
    $display("asymmetric_distortion_chain_unit: mismatch");
    $finish;
  end

  // receiver: stall pattern plus a long hold-off window
  initial begin
    int ph;
    ph = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) chain_sb.check_output(sample_out, end_of_block_out);
      ph++;
      if (hold_off) out_ready <= 1'b0;
      else if (ph % 400 < 100) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // send one sample, holding it until the transfer
  task automatic send_sample(logic [23:0] smp, logic eob);
    in_valid <= 1'b1;
    sample_in <= smp;
    end_of_block <= eob;
    chain_sb.note_input(smp, eob);
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // write one knob register while the chain is empty
  task automatic write_reg(cfg_reg_t idx, logic [KNOB_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    chain_sb.write_knob(int'(idx), longint'(val));
    @(posedge clk);
  endtask

  // unknown index: must be ignored
  task automatic write_unknown(logic [CFG_IDX_W-1:0] idx, logic [KNOB_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (chain_sb.pending_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 255)) - 24'd128;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick_knob();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'h10000;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // burst of random samples with random gaps
  task automatic random_run(int cnt);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < cnt; i++) begin
      if (burst <= 0) begin
        burst = $urandom_range(1, 20);
        gap = $urandom_range(0, 150);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_sample(pick_sample(), $urandom_range(0, 7) == 0);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [23:0] directed [12];
    chain_sb = new();
    chain_sb.clear_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, full-scale, DC step, block markers
    directed = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001, 24'hFFFFFF,
                 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h400000,
                 24'hA66666, 24'h555555};
    foreach (directed[i]) send_sample(directed[i], i[0]);
    in_valid <= 1'b0;
    drain();

    // knobs at the extremes, knob above one, unknown index
    write_reg(REG_GAIN, 17'h10000);
    write_reg(REG_TONE, 17'd0);
    write_reg(REG_PRESENCE, 17'h1FFFF);
    write_reg(REG_LEVEL, 17'h10000);
    write_reg(REG_LPA, 17'h1FFFF);
    write_reg(REG_HPA, 17'd0);
    write_unknown(3'd6, 17'd5);
    write_unknown(3'd7, 17'h1FFFF);
    for (int i = 0; i < 8; i++) send_sample(directed[i], 1'b1);
    in_valid <= 1'b0;
    drain();

    // long receiver hold-off while the sender keeps offering samples
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_sample(pick_sample(), 1'b0);
    join
    in_valid <= 1'b0;
    drain();

    // random phases, each under a new knob setting
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_GAIN, (ph == 0) ? 17'd0 : pick_knob());
      write_reg(REG_TONE, (ph == 1) ? 17'h10000 : pick_knob());
      write_reg(REG_PRESENCE, (ph == 0) ? 17'd0 : pick_knob());
      write_reg(REG_LEVEL, (ph == 2) ? 17'd0 : pick_knob());
      write_reg(REG_LPA, (ph == 3) ? 17'd0 : pick_knob());
      write_reg(REG_HPA, (ph == 4) ? 17'h10000 : pick_knob());
      random_run(100);
      drain();
    end

    if (chain_sb.errors == 0 && chain_sb.pending_q.size() == 0)
      $display("asymmetric_distortion_chain_unit: match");
    else
      $display("asymmetric_distortion_chain_unit: mismatch");
    $finish;
  end
endmodule
